[design/enp_pkg.sv]
package enp_pkg;

    localparam int FRAC_BITS_DEF  = 16;
    localparam int DATA_WIDTH_DEF = 32;
    localparam int REG_WIDTH      = 32;
    localparam int SUM_WIDTH      = 47;
    localparam int INTER_WIDTH    = 63;
    localparam int MUL_DIGIT      = 16;
    localparam int CFG_IDX_WIDTH  = 2;
    localparam int PC_WIDTH       = 5;

    typedef logic [PC_WIDTH-1:0] t_pc;

    typedef enum logic [CFG_IDX_WIDTH-1:0] {
        REG_L1   = 2'd0,
        REG_L2   = 2'd1,
        REG_STEP = 2'd2
    } t_reg_idx;

    typedef enum logic [3:0] {
        U_NOP,
        U_ACCEPT,
        U_MUL_LOAD,
        U_MUL_STEP,
        U_MUL_STORE,
        U_DIV_LOAD,
        U_DIV_STEP,
        U_DIV_STORE,
        U_EMIT
    } t_uop;

    typedef enum logic [2:0] {
        M_GM,
        M_LG,
        M_T1,
        M_LV,
        M_T2
    } t_msel;

    typedef enum logic [2:0] {
        C_NONE,
        C_ALWAYS,
        C_MODE0,
        C_COEF_OK,
        C_CNT_NZ
    } t_cond;

    typedef struct packed {
        t_uop  op;
        t_msel msel;
        t_cond cond;
        t_pc   target;
    } t_ucw;

    typedef struct packed {
        t_uop  op;
        t_msel msel;
        logic  en;
    } t_dp_ctl;

    typedef struct packed {
        logic cnt_zero;
        logic coef_ok;
        logic mode;
    } t_dp_sts;

    localparam t_pc PC_ACCEPT = 5'd0;
    localparam t_pc PC_GM     = 5'd3;
    localparam t_pc PC_LG     = 5'd6;
    localparam t_pc PC_DIV    = 5'd9;
    localparam t_pc PC_T1     = 5'd12;
    localparam t_pc PC_LV     = 5'd15;
    localparam t_pc PC_T2     = 5'd18;
    localparam t_pc PC_EMIT   = 5'd21;

    function automatic t_ucw ucode_rom(input t_pc pc);
        t_ucw w;
        unique case (pc)
            5'd0:    w = '{U_ACCEPT,    M_GM, C_NONE,    PC_ACCEPT};
            5'd1:    w = '{U_NOP,       M_GM, C_MODE0,   PC_T1};
            5'd2:    w = '{U_NOP,       M_GM, C_COEF_OK, PC_DIV};
            5'd3:    w = '{U_MUL_LOAD,  M_GM, C_NONE,    PC_ACCEPT};
            5'd4:    w = '{U_MUL_STEP,  M_GM, C_CNT_NZ,  PC_GM + 5'd1};
            5'd5:    w = '{U_MUL_STORE, M_GM, C_NONE,    PC_ACCEPT};
            5'd6:    w = '{U_MUL_LOAD,  M_LG, C_NONE,    PC_ACCEPT};
            5'd7:    w = '{U_MUL_STEP,  M_LG, C_CNT_NZ,  PC_LG + 5'd1};
            5'd8:    w = '{U_MUL_STORE, M_LG, C_NONE,    PC_ACCEPT};
            5'd9:    w = '{U_DIV_LOAD,  M_GM, C_NONE,    PC_ACCEPT};
            5'd10:   w = '{U_DIV_STEP,  M_GM, C_CNT_NZ,  PC_DIV + 5'd1};
            5'd11:   w = '{U_DIV_STORE, M_GM, C_NONE,    PC_ACCEPT};
            5'd12:   w = '{U_MUL_LOAD,  M_T1, C_NONE,    PC_ACCEPT};
            5'd13:   w = '{U_MUL_STEP,  M_T1, C_CNT_NZ,  PC_T1 + 5'd1};
            5'd14:   w = '{U_MUL_STORE, M_T1, C_NONE,    PC_ACCEPT};
            5'd15:   w = '{U_MUL_LOAD,  M_LV, C_NONE,    PC_ACCEPT};
            5'd16:   w = '{U_MUL_STEP,  M_LV, C_CNT_NZ,  PC_LV + 5'd1};
            5'd17:   w = '{U_MUL_STORE, M_LV, C_NONE,    PC_ACCEPT};
            5'd18:   w = '{U_MUL_LOAD,  M_T2, C_NONE,    PC_ACCEPT};
            5'd19:   w = '{U_MUL_STEP,  M_T2, C_CNT_NZ,  PC_T2 + 5'd1};
            5'd20:   w = '{U_MUL_STORE, M_T2, C_NONE,    PC_ACCEPT};
            5'd21:   w = '{U_EMIT,      M_GM, C_ALWAYS,  PC_ACCEPT};
            default: w = '{U_NOP,       M_GM, C_ALWAYS,  PC_ACCEPT};
        endcase
        return w;
    endfunction

endpackage

[design/enp_in_if.sv]
interface enp_in_if
    import enp_pkg::*;
#(
    parameter int DATA_WIDTH = DATA_WIDTH_DEF
) ();
    logic                         valid;
    logic                         ready;
    logic                         mode;
    logic signed [DATA_WIDTH-1:0] element;
    logic                         last_element;

    modport source (output valid, output mode, output element, output last_element,
                    input ready);
    modport sink   (input valid, input mode, input element, input last_element,
                    output ready);
endinterface

[design/enp_out_if.sv]
interface enp_out_if
    import enp_pkg::*;
#(
    parameter int DATA_WIDTH = DATA_WIDTH_DEF
) ();
    logic                         valid;
    logic                         ready;
    logic signed [DATA_WIDTH-1:0] prox_out;
    logic        [SUM_WIDTH-1:0]  running_sum;
    logic                         last_out;

    modport source (output valid, output prox_out, output running_sum, output last_out,
                    input ready);
    modport sink   (input valid, input prox_out, input running_sum, input last_out,
                    output ready);
endinterface

[design/enp_datapath.sv]
module enp_datapath
    import enp_pkg::*;
#(
    parameter int FRAC_BITS  = FRAC_BITS_DEF,
    parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_we,
    input  logic [CFG_IDX_WIDTH-1:0]     i_cfg_idx,
    input  logic [REG_WIDTH-1:0]         i_cfg_data,
    input  t_dp_ctl                      i_ctl,
    output t_dp_sts                      o_sts,
    input  logic                         i_mode,
    input  logic [DATA_WIDTH-1:0]        i_element,
    input  logic                         i_last,
    output logic signed [DATA_WIDTH-1:0] o_prox,
    output logic [SUM_WIDTH-1:0]         o_sum,
    output logic                         o_last
);
    localparam int DW     = DATA_WIDTH;
    localparam int F      = FRAC_BITS;
    localparam int K      = MUL_DIGIT;
    localparam int WA     = INTER_WIDTH;
    localparam int BW_RAW = (DW > REG_WIDTH) ? DW : REG_WIDTH;
    localparam int WB     = ((BW_RAW + K - 1) / K) * K;
    localparam int ND     = WB / K;
    localparam int PW     = WA + WB;
    localparam int QW     = PW - F;
    localparam int GW     = 2 * REG_WIDTH - F;
    localparam int AW     = GW + 1;
    localparam int RW     = AW + 1;
    localparam int EW     = (DW > GW) ? DW : GW;
    localparam int CW     = $clog2(DW);

    localparam logic [AW-1:0]        ONE_FIX   = AW'(1) << F;
    localparam logic [REG_WIDTH-1:0] STEP_INIT = REG_WIDTH'(1) << F;
    localparam logic [SUM_WIDTH-1:0] SUM_MAX   = '1;

    logic [REG_WIDTH-1:0] r_l1, r_l2, r_step;
    logic                 r_coef_ok;
    logic [SUM_WIDTH-1:0] r_acc;
    logic [CW-1:0]        r_cnt;

    logic                 r_mode, r_neg, r_last;
    logic [DW-1:0]        r_ax, r_v;
    logic [GW-1:0]        r_gm;
    logic [AW-1:0]        r_alpha;
    logic [WA-1:0]        r_ma;
    logic [WB-1:0]        r_mb;
    logic [PW-1:0]        r_prod;
    logic [RW-1:0]        r_rem;
    logic [DW-1:0]        r_nsh;
    logic [SUM_WIDTH-1:0] r_t1, r_t2;
    logic [INTER_WIDTH-1:0] r_lv;
    logic [DW-1:0]        r_out_prox;
    logic [SUM_WIDTH-1:0] r_out_sum;
    logic                 r_out_last;

    logic                 in_neg;
    logic [DW-1:0]        in_ax;
    logic [WA-1:0]        a_op;
    logic [WB-1:0]        b_op;
    logic [WA+K-1:0]      prod_inc;
    logic [QW-1:0]        q;
    logic [EW-1:0]        gm_diff;
    logic [DW-1:0]        num;
    logic [DW+F-1:0]      num_full;
    logic [RW-1:0]        rem2;
    logic                 rem_ge;
    logic [SUM_WIDTH:0]   term_raw, sum_raw;
    logic [SUM_WIDTH-1:0] term, sum;
    logic                 fire;

    assign fire   = i_ctl.en;
    assign in_neg = i_element[DW-1];
    assign in_ax  = in_neg ? ('0 - i_element) : i_element;

    always_comb begin
        unique case (i_ctl.msel)
            M_GM: begin
                a_op = WA'(r_step);
                b_op = WB'(r_l1);
            end
            M_LG: begin
                a_op = WA'(r_l2);
                b_op = WB'(r_step);
            end
            M_T1: begin
                a_op = WA'(r_v);
                b_op = WB'(r_l1);
            end
            M_LV: begin
                a_op = WA'(r_v);
                b_op = WB'(r_l2);
            end
            M_T2: begin
                a_op = r_lv;
                b_op = WB'(r_v);
            end
            default: begin
                a_op = '0;
                b_op = '0;
            end
        endcase
    end

    assign prod_inc = r_ma * r_mb[WB-1 -: K];
    assign q        = r_prod[PW-1:F];

    assign gm_diff  = EW'(r_ax) - EW'(r_gm);
    assign num      = (EW'(r_ax) > EW'(r_gm)) ? gm_diff[DW-1:0] : '0;
    assign num_full = {num, {F{1'b0}}};

    assign rem2   = {r_rem[RW-2:0], r_nsh[DW-1]};
    assign rem_ge = rem2 >= RW'(r_alpha);

    assign term_raw = (SUM_WIDTH + 1)'(r_t1) + (SUM_WIDTH + 1)'(r_t2);
    assign term     = term_raw[SUM_WIDTH] ? SUM_MAX : term_raw[SUM_WIDTH-1:0];
    assign sum_raw  = (SUM_WIDTH + 1)'(r_acc) + (SUM_WIDTH + 1)'(term);
    assign sum      = sum_raw[SUM_WIDTH] ? SUM_MAX : sum_raw[SUM_WIDTH-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_l1      <= '0;
            r_l2      <= '0;
            r_step    <= STEP_INIT;
            r_coef_ok <= 1'b0;
            r_acc     <= '0;
            r_cnt     <= '0;
        end else begin
            if (i_cfg_we) begin
                r_coef_ok <= 1'b0;
                unique case (i_cfg_idx)
                    REG_L1:   r_l1   <= i_cfg_data;
                    REG_L2:   r_l2   <= i_cfg_data;
                    REG_STEP: r_step <= i_cfg_data;
                    default: ;
                endcase
            end
            if (fire) begin
                unique case (i_ctl.op)
                    U_MUL_LOAD:  r_cnt <= CW'(ND - 1);
                    U_DIV_LOAD:  r_cnt <= CW'(DW - 1);
                    U_MUL_STEP,
                    U_DIV_STEP:  r_cnt <= r_cnt - CW'(1);
                    U_MUL_STORE: begin
                        if (i_ctl.msel == M_LG && !i_cfg_we) begin
                            r_coef_ok <= 1'b1;
                        end
                    end
                    U_EMIT:      r_acc <= r_last ? '0 : sum;
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            unique case (i_ctl.op)
                U_ACCEPT: begin
                    r_mode <= i_mode;
                    r_neg  <= in_neg;
                    r_last <= i_last;
                    r_ax   <= in_ax;
                    r_v    <= in_ax;
                end
                U_MUL_LOAD: begin
                    r_ma   <= a_op;
                    r_mb   <= b_op;
                    r_prod <= '0;
                end
                U_MUL_STEP: begin
                    r_prod <= {r_prod[PW-K-1:0], {K{1'b0}}} + PW'(prod_inc);
                    r_mb   <= {r_mb[WB-K-1:0], {K{1'b0}}};
                end
                U_MUL_STORE: begin
                    unique case (i_ctl.msel)
                        M_GM: r_gm    <= q[GW-1:0];
                        M_LG: r_alpha <= ONE_FIX + AW'(q[GW-1:0]);
                        M_T1: r_t1    <= (|q[QW-1:SUM_WIDTH]) ? SUM_MAX : q[SUM_WIDTH-1:0];
                        M_LV: r_lv    <= (|q[QW-1:INTER_WIDTH]) ? '1 : q[INTER_WIDTH-1:0];
                        M_T2: r_t2    <= (|q[QW-1:SUM_WIDTH+1]) ? SUM_MAX : q[SUM_WIDTH:1];
                        default: ;
                    endcase
                end
                U_DIV_LOAD: begin
                    r_rem <= RW'(num_full[DW+F-1:DW]);
                    r_nsh <= num_full[DW-1:0];
                end
                U_DIV_STEP: begin
                    r_rem <= rem_ge ? (rem2 - RW'(r_alpha)) : rem2;
                    r_nsh <= {r_nsh[DW-2:0], rem_ge};
                end
                U_DIV_STORE: r_v <= r_nsh;
                U_EMIT: begin
                    r_out_prox <= r_neg ? ('0 - r_v) : r_v;
                    r_out_sum  <= sum;
                    r_out_last <= r_last;
                end
                default: ;
            endcase
        end
    end

    assign o_sts.cnt_zero = (r_cnt == '0);
    assign o_sts.coef_ok  = r_coef_ok;
    assign o_sts.mode     = r_mode;
    assign o_prox         = $signed(r_out_prox);
    assign o_sum          = r_out_sum;
    assign o_last         = r_out_last;

    a_cfg_drops_coef: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cfg_we |=> !r_coef_ok)
        else $error("coefficient cache survived a register write");

    a_alpha_floor: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_coef_ok |-> (r_alpha >= ONE_FIX))
        else $error("divisor below one");

    a_shrink_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (fire && i_ctl.op == U_EMIT) |-> (r_v <= r_ax))
        else $error("shrunk magnitude exceeds input magnitude");

endmodule

[design/elastic_net_prox_engine.sv]
// Elastic-net engine. Each item on i_in carries one vector element (signed, FRAC_BITS
// fraction bits), a mode and a last flag. Mode 0 adds mu*|x| + lambda/2*x^2 to a running
// sum and returns x; mode 1 returns sign(x)*max(0,|x|-gamma*mu)/(1+lambda*gamma) and adds
// the same term of that value. Every result item on o_out carries the running sum, which
// saturates and clears after the item marked last. Weights are to be written through the
// i_cfg_* port only while no item is in flight; the block itself does not enforce this.
// A microcode sequencer drives one serial multiplier (MUL_DIGIT bits per cycle, ND digits)
// and one restoring divider (one quotient bit per cycle). One item is worked at a time.
// The first mode 1 item after reset or a register write also computes gamma*mu and
// 1+lambda*gamma. With the default widths ND is 2. The sequencer returns to its
// accept step in the cycle after the previous result is formed.
// The result sits in an output register; the next item is accepted while it waits, and
// the sequencer stalls when a new result is ready before the old one is taken, or when
// no item is offered. Reset clears the sum, sets mu and lambda to 0 and gamma to 1.0.
module elastic_net_prox_engine
    import enp_pkg::*;
#(
    parameter int FRAC_BITS  = FRAC_BITS_DEF,
    parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_cfg_we,
    input  logic [CFG_IDX_WIDTH-1:0] i_cfg_idx,
    input  logic [REG_WIDTH-1:0]     i_cfg_data,
    enp_in_if.sink                   i_in,
    enp_out_if.source                o_out
);
    t_pc     r_pc, n_pc;
    logic    r_out_valid, n_out_valid;
    t_ucw    ucw;
    t_dp_ctl ctl;
    t_dp_sts sts;
    logic    stall, take_jump, in_fire, emit_fire;

    assign ucw = ucode_rom(r_pc);

    assign stall = (ucw.op == U_ACCEPT && !i_in.valid) ||
                   (ucw.op == U_EMIT && r_out_valid && !o_out.ready);

    assign in_fire   = i_in.valid && i_in.ready;
    assign emit_fire = (ucw.op == U_EMIT) && !stall;

    always_comb begin
        unique case (ucw.cond)
            C_NONE:    take_jump = 1'b0;
            C_ALWAYS:  take_jump = 1'b1;
            C_MODE0:   take_jump = !sts.mode;
            C_COEF_OK: take_jump = sts.coef_ok;
            C_CNT_NZ:  take_jump = !sts.cnt_zero;
            default:   take_jump = 1'b0;
        endcase
    end

    always_comb begin
        if (stall) begin
            n_pc = r_pc;
        end else if (take_jump) begin
            n_pc = ucw.target;
        end else begin
            n_pc = r_pc + t_pc'(1);
        end
    end

    always_comb begin
        if (emit_fire) begin
            n_out_valid = 1'b1;
        end else if (o_out.ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc        <= PC_ACCEPT;
            r_out_valid <= 1'b0;
        end else begin
            r_pc        <= n_pc;
            r_out_valid <= n_out_valid;
        end
    end

    assign ctl.op   = ucw.op;
    assign ctl.msel = ucw.msel;
    assign ctl.en   = !stall;

    assign i_in.ready  = (ucw.op == U_ACCEPT);
    assign o_out.valid = r_out_valid;

    enp_datapath #(
        .FRAC_BITS  (FRAC_BITS),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_ctl      (ctl),
        .o_sts      (sts),
        .i_mode     (i_in.mode),
        .i_element  (i_in.element),
        .i_last     (i_in.last_element),
        .o_prox     (o_out.prox_out),
        .o_sum      (o_out.running_sum),
        .o_last     (o_out.last_out)
    );

    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_fire |=> !i_in.ready)
        else $error("second item accepted while one is in flight");

    a_valid_from_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(emit_fire))
        else $error("result appeared without an emit step");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        emit_fire |-> (!r_out_valid || o_out.ready))
        else $error("pending result overwritten");

endmodule
